### rtl/core/nonzero_window_average_assert.svh
// assertion macros shared by the nonzero window average modules
// each macro expects clk_i and rst_ni in the enclosing module
`ifndef NONZERO_WINDOW_AVERAGE_ASSERT_SVH
`define NONZERO_WINDOW_AVERAGE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define NWA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define NWA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/nwa_pkg.sv
`timescale 1ns / 1ps

package nwa_pkg;

  // window and field sizing
  localparam int WINDOW_LENGTH = 8;
  localparam int SAMPLE_W      = 16;
  localparam int SUM_W         = SAMPLE_W + $clog2(WINDOW_LENGTH);
  localparam int CNT_W         = $clog2(WINDOW_LENGTH + 1);
  localparam int STEP_W        = $clog2(SUM_W);

  // queue between front and back
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  // one job handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } avg_job_t;

  // one finished result
  typedef struct packed {
    logic                is_empty;
    logic                is_near;
    logic [SAMPLE_W-1:0] window_mean;
  } avg_res_t;

endpackage

### rtl/core/nonzero_window_average.sv
`timescale 1ns / 1ps
// Mean of the nonzero range samples among the last WINDOW_LENGTH inputs.
// Input stream s_axis: one 16-bit range sample per transfer, zero = no echo.
// Output stream m_axis: one result per input sample, in order; tdata holds
// the truncated mean, tuser the near and empty flags.
// Config channel cfg_*: writes the 16-bit obstacle distance; always ready.
// The front keeps the window, a running sum and a nonzero count, and pushes
// one job per sample into a two-entry queue; it accepts a sample every cycle
// while that queue has room.
// The back runs a restoring divider, one quotient bit per cycle over the
// 19-bit sum (SUM_W steps), then registers the result; it takes the next job
// from the queue only once the last result is in the output register.
// Reset clears the window (all zero), the sum, the count, the queue and the
// obstacle distance (zero); m_axis_tvalid is low after reset.
// A stalled receiver holds the result in the output register; the back waits
// for it and the queue then fills, after which s_axis_tready drops.
module nonzero_window_average (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] range_sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] window_mean
  output logic [1:0]  m_axis_tuser,   // [0] is_near, [1] is_empty
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i      // [15:0] obstacle_distance
);
  import nwa_pkg::*;

  logic [SAMPLE_W-1:0] obstacle_distance_q;
  logic                push;
  avg_job_t            push_job;
  logic                queue_full;
  logic                job_valid;
  avg_job_t            job;
  logic                job_ready;
  avg_res_t            res;

  // configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obstacle_distance_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      obstacle_distance_q <= cfg_data_i;
    end
  end

  nwa_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .range_sample_i (s_axis_tdata),
    .push_o         (push),
    .push_job_o     (push_job),
    .queue_full_i   (queue_full)
  );

  nwa_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_job_i  (push_job),
    .full_o      (queue_full),
    .pop_valid_o (job_valid),
    .pop_job_o   (job),
    .pop_ready_i (job_ready)
  );

  nwa_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .job_valid_i         (job_valid),
    .job_i               (job),
    .job_ready_o         (job_ready),
    .obstacle_distance_i (obstacle_distance_q),
    .res_valid_o         (m_axis_tvalid),
    .res_o               (res),
    .res_ready_i         (m_axis_tready)
  );

  // output packing
  assign m_axis_tdata = res.window_mean;
  assign m_axis_tuser = {res.is_empty, res.is_near};

endmodule

### rtl/core/nwa_front.sv
`timescale 1ns / 1ps
`include "nonzero_window_average_assert.svh"

module nwa_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [nwa_pkg::SAMPLE_W-1:0]  range_sample_i,
  output logic                          push_o,
  output nwa_pkg::avg_job_t             push_job_o,
  input  logic                          queue_full_i
);
  import nwa_pkg::*;

  logic [SAMPLE_W-1:0] window_q [WINDOW_LENGTH];
  logic [SAMPLE_W-1:0] window_d [WINDOW_LENGTH];
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                accept;
  logic                new_nz, old_nz;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // shift line, newest sample at the front
  always_comb begin
    window_d[0] = range_sample_i;
    for (int i = 1; i < WINDOW_LENGTH; i++) begin
      window_d[i] = window_q[i-1];
    end
  end

  // running sum and nonzero count, oldest entry falls out
  assign new_nz  = (range_sample_i != '0);
  assign old_nz  = (window_q[WINDOW_LENGTH-1] != '0);
  assign sum_d   = sum_q + SUM_W'(range_sample_i) - SUM_W'(window_q[WINDOW_LENGTH-1]);
  assign count_d = count_q + CNT_W'(new_nz) - CNT_W'(old_nz);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
        window_q[i] <= '0;
      end
    end else if (accept) begin
      sum_q   <= sum_d;
      count_q <= count_d;
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
        window_q[i] <= window_d[i];
      end
    end
  end

  // job goes straight into the queue on each transfer
  assign push_o           = accept;
  assign push_job_o.sum   = sum_d;
  assign push_job_o.count = count_d;

  `NWA_ASSERT_NOW(a_empty_sum_zero, count_q == '0, sum_q == '0, "sum nonzero with empty window")
  `NWA_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(WINDOW_LENGTH), "count above window")

endmodule

### rtl/core/nwa_queue.sv
`timescale 1ns / 1ps

module nwa_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  nwa_pkg::avg_job_t push_job_i,
  output logic              full_o,
  output logic              pop_valid_o,
  output nwa_pkg::avg_job_t pop_job_o,
  input  logic              pop_ready_i
);
  import nwa_pkg::*;

  avg_job_t          slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] fill_q;
  logic              do_push, do_pop;

  assign full_o      = (fill_q == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o = (fill_q != '0);
  assign pop_job_o   = slot_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_valid_o && pop_ready_i;

  // payload slots
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      fill_q <= fill_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

endmodule

### rtl/core/nwa_back.sv
`timescale 1ns / 1ps
`include "nonzero_window_average_assert.svh"

module nwa_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  input  nwa_pkg::avg_job_t             job_i,
  output logic                          job_ready_o,
  input  logic [nwa_pkg::SAMPLE_W-1:0]  obstacle_distance_i,
  output logic                          res_valid_o,
  output nwa_pkg::avg_res_t             res_o,
  input  logic                          res_ready_i
);
  import nwa_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } state_e;

  state_e             state_q;
  logic [SUM_W-1:0]   dvd_q;
  logic [CNT_W-1:0]   div_q;
  logic [CNT_W-1:0]   rem_q;
  logic [STEP_W-1:0]  step_q;
  logic               empty_q;
  logic               res_valid_q;
  avg_res_t           res_q;

  logic [CNT_W:0]     trial;
  logic [CNT_W:0]     diff;
  logic               qbit;
  logic [SAMPLE_W-1:0] mean;
  logic               out_free;

  // one restoring step: bring in the next dividend bit, subtract if it fits
  assign trial = {rem_q, dvd_q[SUM_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign qbit  = (trial >= {1'b0, div_q});

  assign mean     = empty_q ? '0 : dvd_q[SAMPLE_W-1:0];
  assign out_free = !res_valid_q || res_ready_i;

  assign job_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // sequencer with divider and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dvd_q       <= '0;
      div_q       <= '0;
      rem_q       <= '0;
      step_q      <= '0;
      empty_q     <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      // result taken while no new one is being loaded
      if (res_valid_q && res_ready_i && (state_q != ST_HOLD)) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            dvd_q   <= job_i.sum;
            div_q   <= job_i.count;
            rem_q   <= '0;
            step_q  <= STEP_W'(SUM_W - 1);
            empty_q <= (job_i.count == '0);
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q  <= qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
          dvd_q  <= {dvd_q[SUM_W-2:0], qbit};
          step_q <= step_q - 1'b1;
          if (step_q == '0) begin
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            res_q.window_mean <= mean;
            res_q.is_empty    <= empty_q;
            res_q.is_near     <= !empty_q && (mean < obstacle_distance_i);
            res_valid_q       <= 1'b1;
            state_q           <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `NWA_ASSERT_NOW(a_rem_below_div, (state_q == ST_DIV) && (div_q != '0), rem_q < div_q, "remainder not below divisor")
  `NWA_ASSERT_NEXT(a_take_job, (state_q == ST_IDLE) && job_valid_i, state_q == ST_DIV, "job not taken")
  `NWA_ASSERT_NOW(a_empty_result, res_valid_q && res_q.is_empty, (res_q.window_mean == '0) && !res_q.is_near, "empty result not cleared")

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import nwa_pkg::*;

  // opening samples: empty window, full-scale window, threshold edges, bit patterns
  localparam logic [SAMPLE_W-1:0] OPENING [23] = '{
    16'd0, 16'hFFFF, 16'd0,
    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
    16'd1000, 16'd998, 16'd1, 16'hAAAA, 16'h5555
  };

  // obstacle distance per random phase; the fourth is drawn at random
  localparam logic [SAMPLE_W-1:0] PHASE_LIMIT [5] = '{
    16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd300
  };
  localparam int PHASE_ITEMS = 250;

  // window of recent range samples and the means it should produce
  class range_mean_board;
    logic [SAMPLE_W-1:0] history [WINDOW_LENGTH];
    logic [SAMPLE_W-1:0] near_limit;
    avg_res_t            awaited [$];
    int unsigned         faults;

    function new();
      foreach (history[i]) history[i] = '0;
      near_limit = '0;
      faults     = 0;
    endfunction

    // shift in an accepted sample and queue the mean it yields
    function void note_sample(logic [SAMPLE_W-1:0] sample);
      logic [31:0] total;
      logic [31:0] hits;
      avg_res_t    res;
      total = '0;
      hits  = '0;
      for (int i = WINDOW_LENGTH - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = sample;
      foreach (history[i]) begin
        if (history[i] != '0) begin
          total += history[i];
          hits++;
        end
      end
      res.is_empty    = (hits == 0);
      res.window_mean = res.is_empty ? '0 : SAMPLE_W'(total / hits);
      res.is_near     = !res.is_empty && (res.window_mean < near_limit);
      awaited.push_back(res);
    endfunction

    // compare one result transfer with the oldest queued mean
    function void check_result(avg_res_t seen);
      avg_res_t want;
      if (awaited.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("result with none pending: mean %0d near %0b empty %0b",
                   seen.window_mean, seen.is_near, seen.is_empty);
        return;
      end
      want = awaited.pop_front();
      if (seen.window_mean !== want.window_mean || seen.is_near !== want.is_near ||
          seen.is_empty !== want.is_empty) begin
        faults++;
        if (faults <= 10)
          $display("wrong result: expected mean %0d near %0b empty %0b, got mean %0d near %0b empty %0b",
                   want.window_mean, want.is_near, want.is_empty,
                   seen.window_mean, seen.is_near, seen.is_empty);
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [SAMPLE_W-1:0] s_axis_tdata;   // [15:0] range_sample
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [SAMPLE_W-1:0] m_axis_tdata;   // [15:0] window_mean
  logic [1:0]          m_axis_tuser;   // [0] is_near, [1] is_empty
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [SAMPLE_W-1:0] cfg_data_i;     // [15:0] obstacle_distance

  range_mean_board board;
  bit              tx_calm;
  bit              rx_calm;

  nonzero_window_average dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 30);
    return $urandom_range(31, 80);
  endfunction

  // range reading: no echo, full scale, tiny, around the short threshold, anything
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return '0;
    if (r < 28) return '1;
    if (r < 38) return SAMPLE_W'($urandom_range(1, 15));
    if (r < 48) return SAMPLE_W'($urandom_range(200, 400));
    return SAMPLE_W'($urandom_range(0, 65535));
  endfunction

  // one sample transfer, after an optional idle gap
  task automatic push_sample(input logic [SAMPLE_W-1:0] sample);
    int unsigned gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sample;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_sample(sample);
  endtask

  // hold the sender until every pending mean has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk_i);
  endtask

  // obstacle distance write, only while the block is idle
  task automatic set_near_limit(input logic [SAMPLE_W-1:0] limit);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= limit;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    board.near_limit = limit;
  endtask

  // receiver: check each result transfer, stall at random
  initial begin
    int unsigned hold;
    hold          = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready)
        board.check_result({m_axis_tuser, m_axis_tdata});
      if (hold != 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!rx_calm && $urandom_range(0, 99) < 25) hold = pick_gap();
      end
    end
  end

  // stimulus and verdict
  initial begin
    logic [SAMPLE_W-1:0] limit;
    board         = new();
    tx_calm       = 1'b0;
    rx_calm       = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_near_limit(16'd1000);
    foreach (OPENING[i]) push_sample(OPENING[i]);

    for (int p = 0; p < 5; p++) begin
      drain();
      limit = (p == 3) ? SAMPLE_W'($urandom_range(2, 65534)) : PHASE_LIMIT[p];
      set_near_limit(limit);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // stretches without idling on one side or the other
        if (n % 40 == 0) begin
          tx_calm = ($urandom_range(0, 3) == 0);
          rx_calm = ($urandom_range(0, 3) == 0);
        end
        if (p == 2 && n == PHASE_ITEMS / 2) drain();
        // a run of missed echoes empties the window
        if ($urandom_range(0, 99) < 3) begin
          repeat ($urandom_range(8, 12)) push_sample('0);
        end else begin
          push_sample(pick_sample());
        end
      end
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (board.awaited.size() != 0)
      $display("%0d results never arrived", board.awaited.size());
    if (board.faults == 0 && board.awaited.size() == 0) begin
      $display("nonzero_window_average: match");
    end else begin
      $display("nonzero_window_average: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("nonzero_window_average: mismatch");
    $finish;
  end

endmodule
